/* sv/iblx_pkg.sv */
`timescale 1ns / 1ps

package iblx_pkg;

  // command codes of a request
  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  // one request on the input channel
  typedef struct packed {
    logic        cmd;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] now;
    logic [31:0] block_time;
  } in_req_t;

  // one result on the output channel
  typedef struct packed {
    logic drop;
    logic table_full;
  } out_rsp_t;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clr_we;   // write one cleared row of the sweep
    logic rd_en;    // request accepted: capture it and read its bucket
    logic eval;     // evaluate the bucket, update it, load the result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // sweep is at its last row
    logic out_busy;  // result register full and held by the receiver
  } dp_sts_t;

endpackage

/* sv/iblx_ctrl.sv */
`timescale 1ns / 1ps

module iblx_ctrl import iblx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t dp_sts_i,
  output dp_cmd_t dp_cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    dp_cmd_o   = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        dp_cmd_o.clr_we = 1'b1;
        if (dp_sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          dp_cmd_o.rd_en = 1'b1;
          state_d        = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // wait while the previous result is still held
        if (!dp_sts_i.out_busy) begin
          dp_cmd_o.eval = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

/* sv/iblx_dp.sv */
`timescale 1ns / 1ps

module iblx_dp import iblx_pkg::*; #(
  parameter int BUCKET_BITS = 8,
  parameter int WAYS        = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic     clk_i,
  input  logic     in_valid_i,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o,
  input  logic     rst_ni,
  input  dp_cmd_t  dp_cmd_i,
  output dp_sts_t  dp_sts_o
);

  localparam int NUM_ROWS = 1 << BUCKET_BITS;
  localparam int SUM_W    = (TIME_BITS > 32 ? TIME_BITS : 32) + 1;

  // one bucket holds all of its ways
  typedef struct packed {
    logic [WAYS-1:0]                vld;
    logic [WAYS-1:0][63:0]          hi;
    logic [WAYS-1:0][63:0]          lo;
    logic [WAYS-1:0][TIME_BITS-1:0] exp;
  } row_t;

  row_t                   mem_q [NUM_ROWS];
  row_t                   rd_q;
  row_t                   wr_row;
  in_req_t                req_q;
  logic [BUCKET_BITS-1:0] bucket_q;
  logic [BUCKET_BITS-1:0] rd_bucket;
  logic [BUCKET_BITS-1:0] clr_cnt_q;
  logic [BUCKET_BITS-1:0] wr_addr;
  logic [63:0]            key;
  logic                   we;
  logic [TIME_BITS-1:0]   now_t;
  logic [SUM_W-1:0]       sum;
  logic [TIME_BITS-1:0]   expiry;
  logic [WAYS-1:0]        hit;
  logic [WAYS-1:0]        free;
  logic [WAYS-1:0]        sel;
  logic                   is_add;
  logic                   out_valid_q;
  out_rsp_t               out_q;
  out_rsp_t               rsp;

  // bucket hash of the incoming address
  assign key = {in_req_i.addr_hi[63:32], 32'b0}
             ^ {8'b0, in_req_i.addr_hi[31:0], 24'b0}
             ^ {24'b0, in_req_i.addr_lo[63:32], 8'b0}
             ^ {32'b0, in_req_i.addr_lo[31:0]};
  assign rd_bucket = key[BUCKET_BITS-1:0];

  // request capture
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.rd_en) begin
      req_q    <= in_req_i;
      bucket_q <= rd_bucket;
    end
  end

  // clear sweep row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (dp_cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + BUCKET_BITS'(1);
    end
  end
  assign dp_sts_o.clr_last = &clr_cnt_q;

  // expiry of a new rule, saturated to the time range; a zero duration gives the top value
  assign now_t = TIME_BITS'(req_q.now);
  assign sum   = SUM_W'(now_t) + SUM_W'(req_q.block_time);
  always_comb begin
    if (req_q.block_time == 32'd0 || sum[SUM_W-1:TIME_BITS] != '0) begin
      expiry = '1;
    end else begin
      expiry = sum[TIME_BITS-1:0];
    end
  end

  // per way match and reuse flags
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w]  = rd_q.vld[w] && rd_q.hi[w] == req_q.addr_hi &&
                rd_q.lo[w] == req_q.addr_lo && now_t <= rd_q.exp[w];
      free[w] = !rd_q.vld[w] || now_t > rd_q.exp[w];
    end
  end

  // lowest reusable way
  assign sel    = free & (~free + WAYS'(1));
  assign is_add = req_q.cmd == CMD_ADD;

  assign rsp.drop       = !is_add && (|hit);
  assign rsp.table_full = is_add && !(|free);

  // updated bucket, or an empty one during the sweep
  always_comb begin
    wr_row = rd_q;
    for (int w = 0; w < WAYS; w++) begin
      if (sel[w]) begin
        wr_row.vld[w] = 1'b1;
        wr_row.hi[w]  = req_q.addr_hi;
        wr_row.lo[w]  = req_q.addr_lo;
        wr_row.exp[w] = expiry;
      end
    end
    if (dp_cmd_i.clr_we) begin
      wr_row = '0;
    end
  end

  assign we      = dp_cmd_i.clr_we || (dp_cmd_i.eval && is_add && (|free));
  assign wr_addr = dp_cmd_i.clr_we ? clr_cnt_q : bucket_q;

  // rule memory, one bucket per row
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (dp_cmd_i.rd_en && in_valid_i) begin
      rd_q <= mem_q[rd_bucket];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd_i.eval) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.eval) begin
      out_q <= rsp;
    end
  end

  assign dp_sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_rsp_o         = out_q;

endmodule

/* sv/ip_blocklist_expiry_table.sv */
`timescale 1ns / 1ps
// IP blocklist with expiry: a set-associative table of blocking rules.
// Input channel (in_valid_i / in_stall_o / in_req_i): one request carries
// a command, a 128-bit source address (IPv4 as v4-mapped), the current
// time and, for an add, a block duration (0 is permanent).
// A check answers drop when a live rule for the address sits in its bucket;
// an add writes the rule into the first free or expired way of the bucket,
// or reports table_full.
// Output channel (out_valid_o / out_stall_i / out_rsp_o): one result per
// request, in request order.
// Timing: the cycle that takes a request reads its bucket row from the
// rule memory; the EVAL state then compares all ways, writes the row
// back and loads the result register, once no earlier result is held.
// A new request is taken only after the previous one is evaluated.
// Reset: the table is swept clear, one bucket row a cycle, through all
// 2^BUCKET_BITS rows; in_stall_o stays high during the sweep.
// A stalled result holds; one further request may be taken meanwhile and
// then waits until the held result is taken.

module ip_blocklist_expiry_table import iblx_pkg::*; #(
  parameter int BUCKET_BITS = 8,
  parameter int WAYS        = 4,
  parameter int TIME_BITS   = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // sequencing
  iblx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dp_sts_i   (dp_sts),
    .dp_cmd_o   (dp_cmd)
  );

  // rule memory, lookup and result register
  iblx_dp #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .dp_sts_o    (dp_sts)
  );

endmodule

/* sv/iblx_chk.sv */
`timescale 1ns / 1ps

module iblx_chk import iblx_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_rsp_t out_rsp_o
);

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_rsp_o))
    else $error("result changed while stalled");

  // a result answers exactly one kind of request
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.drop && out_rsp_o.table_full))
    else $error("drop and table_full both set");

  // one request in flight: input closes right after acceptance
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while another is evaluated");

  // a fresh result follows its acceptance through the bucket read and the evaluation
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without matching request");

endmodule

bind ip_blocklist_expiry_table iblx_chk u_iblx_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

/* tb/tb_ip_blocklist_expiry_table.sv */
`timescale 1ns / 1ps

module tb_ip_blocklist_expiry_table;
  import iblx_pkg::*;

  localparam int BUCKET_BITS = 8;
  localparam int WAYS        = 4;
  localparam int TIME_BITS   = 32;
  localparam int NUM_SLOTS   = (1 << BUCKET_BITS) * WAYS;
  localparam logic [TIME_BITS-1:0] TIME_CEIL = '1;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 96;
  localparam int POOL_SIZE    = 24;

  typedef struct {
    in_req_t req;
    bit      hold;  // wait until all earlier results are back
  } queued_req_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  // shadow copy of the rule table
  bit                   slot_used [NUM_SLOTS];
  logic [63:0]          slot_hi   [NUM_SLOTS];
  logic [63:0]          slot_lo   [NUM_SLOTS];
  logic [TIME_BITS-1:0] slot_expiry [NUM_SLOTS];

  queued_req_t req_backlog[$];
  out_rsp_t    pending_verdicts[$];

  int errors;
  int checks_sent, adds_sent, drops_seen, fulls_seen;
  int burst_left, gap_left, mode_left;
  int stall_mode;

  logic [63:0] pool_hi [POOL_SIZE];
  logic [63:0] pool_lo [POOL_SIZE];

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  ip_blocklist_expiry_table #(
    .BUCKET_BITS(BUCKET_BITS),
    .WAYS       (WAYS),
    .TIME_BITS  (TIME_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // verdict of one request; updates the shadow table on an add
  function automatic out_rsp_t blocklist_verdict(in_req_t r);
    logic [63:0]          key;
    logic [BUCKET_BITS-1:0] bkt;
    logic [TIME_BITS-1:0] t_now;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] exp_t;
    int                   base;
    bit                   placed;
    out_rsp_t             rsp;
    key = {r.addr_hi[63:32], 32'h0}
        ^ ({32'h0, r.addr_hi[31:0]} << 24)
        ^ ({32'h0, r.addr_lo[63:32]} << 8)
        ^ {32'h0, r.addr_lo[31:0]};
    bkt    = key[BUCKET_BITS-1:0];
    t_now  = r.now[TIME_BITS-1:0];
    base   = int'(bkt) * WAYS;
    rsp    = '0;
    placed = 1'b0;
    if (r.cmd == CMD_CHECK) begin
      for (int w = 0; w < WAYS; w++) begin
        if (slot_used[base+w] && slot_hi[base+w] == r.addr_hi &&
            slot_lo[base+w] == r.addr_lo && t_now <= slot_expiry[base+w]) begin
          rsp.drop = 1'b1;
        end
      end
    end else begin
      // zero duration is permanent, otherwise saturate the sum
      if (r.block_time == '0) begin
        exp_t = TIME_CEIL;
      end else begin
        sum   = {1'b0, t_now} + {1'b0, r.block_time[TIME_BITS-1:0]};
        exp_t = sum[TIME_BITS] ? TIME_CEIL : sum[TIME_BITS-1:0];
      end
      for (int w = 0; w < WAYS; w++) begin
        if (!placed && (!slot_used[base+w] || t_now > slot_expiry[base+w])) begin
          slot_used[base+w]   = 1'b1;
          slot_hi[base+w]     = r.addr_hi;
          slot_lo[base+w]     = r.addr_lo;
          slot_expiry[base+w] = exp_t;
          placed              = 1'b1;
        end
      end
      rsp.table_full = !placed;
    end
    return rsp;
  endfunction

  task automatic push_req(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                          input logic [31:0] now_t, input logic [31:0] dur, input bit hold);
    queued_req_t q;
    q.req.cmd        = cmd;
    q.req.addr_hi    = hi;
    q.req.addr_lo    = lo;
    q.req.now        = now_t;
    q.req.block_time = dur;
    q.hold           = hold;
    req_backlog.push_back(q);
  endtask

  // request driver: bursts with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive
    bit          busy;
    queued_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      busy = in_valid_i;
      if (in_fire) begin
        pending_verdicts.push_back(blocklist_verdict(in_req_i));
        if (in_req_i.cmd == CMD_CHECK) checks_sent++;
        else adds_sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_backlog.size() > 0 &&
                     !(req_backlog[0].hold && pending_verdicts.size() > 0)) begin
          nxt = req_backlog.pop_front();
          in_req_i   <= nxt.req;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin : observe
    out_rsp_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mode_left   <= 0;
      stall_mode  <= 0;
    end else begin
      if (out_fire) begin
        if (out_rsp_o.drop) drops_seen++;
        if (out_rsp_o.table_full) fulls_seen++;
        if (pending_verdicts.size() == 0) begin
          $display("%0t: unexpected result drop=%0b table_full=%0b", $time,
                   out_rsp_o.drop, out_rsp_o.table_full);
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (want.drop !== out_rsp_o.drop) begin
            $display("%0t: drop expected %0b actual %0b", $time, want.drop, out_rsp_o.drop);
            errors++;
          end
          if (want.table_full !== out_rsp_o.table_full) begin
            $display("%0t: table_full expected %0b actual %0b", $time,
                     want.table_full, out_rsp_o.table_full);
            errors++;
          end
        end
      end
      // modes: never stall, light stall, heavy stall
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 100);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [63:0] a_lo, b_lo, c_hi, c_lo, d_hi, d_lo, e_hi;
    logic [7:0]  bkts [3];
    logic [31:0] tick, dur;
    int          k;
    errors      = 0;
    checks_sent = 0;
    adds_sent   = 0;
    drops_seen  = 0;
    fulls_seen  = 0;

    // directed: extremes, expiry edge, full bucket, reuse, duplicates
    a_lo = 64'h0000_ffff_c0a8_015a;
    b_lo = 64'h0000_ffff_0a00_005a;
    c_hi = 64'h2001_0db8_0000_0001;
    c_lo = 64'h0000_0000_0000_105a;
    d_hi = 64'hfe80_0000_0000_0000;
    d_lo = 64'h0211_22ff_fe33_445a;
    e_hi = 64'h0000_0000_0000_0001;
    push_req(CMD_CHECK, '0, '0, '0, '0, 1'b0);
    push_req(CMD_ADD, '0, '0, '0, '0, 1'b0);
    push_req(CMD_CHECK, '0, '0, '1, '1, 1'b0);
    push_req(CMD_ADD, '1, '1, 32'hffff_fff0, '1, 1'b0);
    push_req(CMD_CHECK, '1, '1, '1, '0, 1'b0);
    push_req(CMD_ADD, '0, a_lo, 100, 1, 1'b0);
    push_req(CMD_CHECK, '0, a_lo, 101, 0, 1'b0);
    push_req(CMD_CHECK, '0, a_lo, 102, 0, 1'b0);
    push_req(CMD_ADD, '0, b_lo, 100, 1000, 1'b0);
    push_req(CMD_ADD, c_hi, c_lo, 100, 1000, 1'b0);
    push_req(CMD_ADD, c_hi, c_lo, 100, 2000, 1'b0);
    push_req(CMD_ADD, d_hi, d_lo, 100, 10, 1'b0);
    push_req(CMD_CHECK, d_hi, d_lo, 100, 0, 1'b0);
    push_req(CMD_ADD, d_hi, d_lo, 102, 10, 1'b0);
    push_req(CMD_CHECK, d_hi, d_lo, 112, 0, 1'b0);
    push_req(CMD_CHECK, '0, a_lo, 50, 0, 1'b0);
    push_req(CMD_CHECK, e_hi, b_lo, 200, 0, 1'b0);
    push_req(CMD_CHECK, '0, b_lo, 1100, 0, 1'b0);
    push_req(CMD_CHECK, '0, b_lo, 1101, 0, 1'b0);
    push_req(CMD_ADD, e_hi, b_lo, 1101, 5, 1'b0);
    push_req(CMD_CHECK, e_hi, b_lo, 1106, 0, 1'b0);

    // random phases over a small address pool packed into three buckets
    for (int p = 0; p < PHASES; p++) begin
      for (int b = 0; b < 3; b++) bkts[b] = 8'($urandom_range(0, 255));
      // only the low byte of the last word reaches the bucket index
      for (int i = 0; i < POOL_SIZE; i++) begin
        if (i % 2 == 0) begin
          pool_hi[i] = '0;
          pool_lo[i] = {32'h0000_ffff, $urandom()};
        end else begin
          pool_hi[i] = {$urandom(), $urandom()};
          pool_lo[i] = {$urandom(), $urandom()};
        end
        pool_lo[i][7:0] = bkts[i % 3];
      end
      tick = (p == 3) ? 32'hffff_ff00 : $urandom_range(0, 1000000);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          push_req(1'($urandom_range(0, 1)), {$urandom(), $urandom()},
                   {$urandom(), $urandom()}, $urandom(), $urandom(), i == 0);
        end else begin
          tick = tick + $urandom_range(0, 4);
          case ($urandom_range(0, 31))
            0:       dur = '0;
            1, 2:    dur = $urandom();
            default: dur = $urandom_range(1, 40);
          endcase
          k = $urandom_range(0, POOL_SIZE - 1);
          push_req(1'($urandom_range(0, 1)), pool_hi[k], pool_lo[k], tick, dur, i == 0);
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() > 0 || in_valid_i || pending_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d checks (%0d dropped) and %0d adds (%0d on a full bucket)",
             checks_sent, drops_seen, adds_sent, fulls_seen);
    $display("with expiry edges, saturation, permanent rules and way reuse; %0d errors",
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
